// ===== rtl/core/tvbe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constant tables for the triangle V-system basis evaluator.
// Depends on nothing; every other file in rtl/core imports it.
package tvbe_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int COORD_W = COORD_FRAC_BITS + 1;
   localparam int SHIFT_W = 3;
   localparam int BASIS_W = 32;
   localparam int NUM_BASIS = 9;
   localparam int NUM_REGIONS = 7;
   localparam int COEF_W = 7;
   localparam int KQ_W = 33;
   localparam int LIN_W = COORD_W + 7;
   localparam int PROD_W = LIN_W + KQ_W;
   localparam int ROUND_BASE = 31;
   localparam int SH_W = $clog2(ROUND_BASE + 1);
   localparam int MIN_SHIFT = ROUND_BASE - ((1 << SHIFT_W) - 1);
   localparam int SHIFTED_W = PROD_W - MIN_SHIFT;

   typedef enum logic [2:0] {
      REG_CORNER_U = 3'd0,
      REG_CORNER_V = 3'd1,
      REG_CORNER_W = 3'd2,
      REG_CENTER   = 3'd3,
      REG_HALF_U   = 3'd4,
      REG_HALF_V   = 3'd5,
      REG_HALF_W   = 3'd6
   } region_type;

   typedef enum logic [2:0] {
      K_ONE  = 3'd0,
      K_S2   = 3'd1,
      K_C23  = 3'd2,
      K_C263 = 3'd3,
      K_S8   = 3'd4,
      K_S24  = 3'd5,
      K_S63  = 3'd6,
      K_S6   = 3'd7
   } k_sel_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] a2;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] c2;
      logic signed [COEF_W-1:0] d2;
      k_sel_type                k;
   } lin_term_type;

   // Scale constants rounded to nearest in units of 2^-30.
   function automatic logic [KQ_W-1:0] kq_value(input k_sel_type k);
      logic [KQ_W-1:0] q;
      unique case (k)
         K_ONE:   q = 33'd1073741824;
         K_S2:    q = 33'd1518500250;
         K_C23:   q = 33'd1239850262;
         K_C263:  q = 33'd1753413056;
         K_S8:    q = 33'd3037000500;
         K_S24:   q = 33'd5260239169;
         K_S63:   q = 33'd876706528;
         K_S6:    q = 33'd2630119584;
         default: q = 33'd0;
      endcase
      return q;
   endfunction

   function automatic lin_term_type mk_term(input int a, input int b, input int c,
                                            input int d, input k_sel_type k);
      lin_term_type t;
      t.a2 = COEF_W'(a);
      t.b2 = COEF_W'(b);
      t.c2 = COEF_W'(c);
      t.d2 = COEF_W'(d);
      t.k  = k;
      return t;
   endfunction

   localparam lin_term_type TERM_ZERO = mk_term(0, 0, 0, 0, K_ONE);

   // Linear forms in half units per region and basis slot.
   localparam lin_term_type REGION_TAB [NUM_REGIONS][NUM_BASIS] = '{
      '{mk_term(-12, 0, 0, 10, K_S2), mk_term(0, -12, 0, 10, K_S2),
        mk_term(0, 0, -12, 10, K_S2), mk_term(36, 0, 0, -24, K_C23),
        TERM_ZERO, TERM_ZERO,
        mk_term(0, 24, -24, 0, K_ONE), TERM_ZERO, TERM_ZERO},
      '{mk_term(-12, 0, 0, 2, K_S2), mk_term(0, -12, 0, 2, K_S2),
        mk_term(0, 0, -12, 2, K_S2), mk_term(-12, 0, 0, 2, K_C23),
        mk_term(-24, 0, 0, -4, K_C263), TERM_ZERO,
        mk_term(0, -8, 8, 4, K_ONE), mk_term(8, 16, 0, -12, K_S8), TERM_ZERO},
      '{mk_term(-12, 0, 0, 2, K_S2), mk_term(0, -12, 0, 2, K_S2),
        mk_term(0, 0, -12, 2, K_S2), mk_term(-12, 0, 0, 2, K_C23),
        mk_term(-12, 0, 0, 2, K_C263), mk_term(12, 0, 0, -2, K_S8),
        mk_term(0, -8, 8, -4, K_ONE), mk_term(-4, -8, 0, 2, K_S8),
        mk_term(4, 8, 0, -2, K_S24)},
      '{mk_term(-12, 0, 0, 2, K_S2), mk_term(0, -12, 0, 2, K_S2),
        mk_term(0, 0, -12, 2, K_S2), mk_term(-12, 0, 0, 4, K_C23),
        mk_term(-12, 0, 0, 4, K_C263), mk_term(-12, 0, 0, 4, K_S8),
        mk_term(0, -8, 8, 0, K_ONE), mk_term(-4, -8, 0, 4, K_S8),
        mk_term(-4, -8, 0, 4, K_S24)},
      '{mk_term(-12, 0, 0, 6, K_S2), mk_term(0, -12, 0, 6, K_S2),
        mk_term(0, 0, -12, 6, K_S2), mk_term(12, 0, 0, -10, K_C23),
        mk_term(-12, 0, 0, 4, K_S63), mk_term(-12, 0, 0, 4, K_S2),
        mk_term(0, 8, -8, 0, K_ONE), mk_term(-4, -8, 0, 4, K_S2),
        mk_term(-4, -8, 0, 4, K_S6)},
      '{mk_term(-12, 0, 0, 2, K_S2), mk_term(0, -12, 0, 2, K_S2),
        mk_term(0, 0, -12, 2, K_S2), mk_term(-12, 0, 0, 3, K_C23),
        mk_term(-18, 0, 0, 0, K_C263), mk_term(-12, 0, 0, 4, K_S2),
        mk_term(0, -8, 8, 2, K_ONE), mk_term(4, 8, 0, -8, K_S2),
        mk_term(-4, -8, 0, 4, K_S6)},
      '{mk_term(-12, 0, 0, 2, K_S2), mk_term(0, -12, 0, 2, K_S2),
        mk_term(0, 0, -12, 2, K_S2), mk_term(-12, 0, 0, 3, K_C23),
        mk_term(-12, 0, 0, 3, K_C263), mk_term(0, 0, 0, 2, K_S2),
        mk_term(0, -8, 8, -2, K_ONE), mk_term(-8, -16, 0, 6, K_S2),
        mk_term(0, 0, 0, 2, K_S6)}
   };

endpackage

// ===== rtl/core/tvbe_classify.sv =====
`timescale 1ns / 1ps
// Region classifier: picks the subtriangle or half-coordinate boundary of a point.
// Depends on tvbe_pkg.
module tvbe_classify (
   input  logic [tvbe_pkg::COORD_W-1:0] coord_u,
   input  logic [tvbe_pkg::COORD_W-1:0] coord_v,
   input  logic [tvbe_pkg::COORD_W-1:0] coord_w,
   output tvbe_pkg::region_type         region
);
   import tvbe_pkg::*;

   localparam logic [COORD_W-1:0] HALF = COORD_W'(1) << (COORD_FRAC_BITS - 1);

   always_comb begin
      priority if (coord_u > HALF) begin
         region = REG_CORNER_U;
      end else if (coord_v > HALF) begin
         region = REG_CORNER_V;
      end else if (coord_w > HALF) begin
         region = REG_CORNER_W;
      end else if (coord_u < HALF && coord_v < HALF && coord_w < HALF) begin
         region = REG_CENTER;
      end else if (coord_u == HALF) begin
         region = REG_HALF_U;
      end else if (coord_v == HALF) begin
         region = REG_HALF_V;
      end else begin
         region = REG_HALF_W;
      end
   end

endmodule

// ===== rtl/core/tvbe_term.sv =====
`timescale 1ns / 1ps
// One basis slot: exact linear form, registered, then times the rounded scale constant, registered.
// Depends on tvbe_pkg.
module tvbe_term (
   input  logic                                clock,
   input  tvbe_pkg::lin_term_type              term,
   input  logic [tvbe_pkg::COORD_W-1:0]        coord_u,
   input  logic [tvbe_pkg::COORD_W-1:0]        coord_v,
   input  logic [tvbe_pkg::COORD_W-1:0]        coord_w,
   output logic signed [tvbe_pkg::PROD_W-1:0]  prod_ff
);
   import tvbe_pkg::*;

   logic signed [LIN_W-1:0]  u_x;
   logic signed [LIN_W-1:0]  v_x;
   logic signed [LIN_W-1:0]  w_x;
   logic signed [LIN_W-1:0]  lin_in;
   logic signed [LIN_W-1:0]  lin_ff;
   logic [KQ_W-1:0]          kq_in;
   logic [KQ_W-1:0]          kq_ff;
   logic signed [KQ_W:0]     kq_x;
   logic signed [PROD_W:0]   prod_full;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      u_x = $signed(LIN_W'(coord_u));
      v_x = $signed(LIN_W'(coord_v));
      w_x = $signed(LIN_W'(coord_w));
      lin_in = LIN_W'(term.a2) * u_x + LIN_W'(term.b2) * v_x + LIN_W'(term.c2) * w_x
               + (LIN_W'(term.d2) <<< COORD_FRAC_BITS);
      kq_in = kq_value(term.k);
   end

   always_comb begin
      kq_x = $signed({1'b0, kq_ff});
      prod_full = lin_ff * kq_x;
      prod_in = prod_full[PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      lin_ff <= lin_in;
      kq_ff <= kq_in;
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/core/tvbe_round.sv =====
`timescale 1ns / 1ps
// Scales a product by 2^(scale - 31), rounds half away from zero and saturates to 32 bits.
// Depends on tvbe_pkg.
module tvbe_round (
   input  logic signed [tvbe_pkg::PROD_W-1:0]  prod,
   input  logic [tvbe_pkg::SHIFT_W-1:0]        scale_shift,
   output logic signed [tvbe_pkg::BASIS_W-1:0] basis
);
   import tvbe_pkg::*;

   localparam logic signed [BASIS_W-1:0] BASIS_MAX = {1'b0, {(BASIS_W - 1){1'b1}}};
   localparam logic signed [BASIS_W-1:0] BASIS_MIN = {1'b1, {(BASIS_W - 1){1'b0}}};
   localparam logic signed [SHIFTED_W-1:0] SAT_HI = SHIFTED_W'(BASIS_MAX);
   localparam logic signed [SHIFTED_W-1:0] SAT_LO = SHIFTED_W'(BASIS_MIN);

   logic [SH_W-1:0]          sh;
   logic [SH_W-1:0]          half_pos;
   logic signed [PROD_W-1:0] bias;
   logic signed [PROD_W-1:0] biased;
   logic signed [PROD_W-1:0] shifted_full;
   logic signed [SHIFTED_W-1:0] shifted;

   // A negative value takes a bias one less than half, which makes the
   // arithmetic shift round ties away from zero.
   always_comb begin
      sh = SH_W'(ROUND_BASE) - SH_W'(scale_shift);
      half_pos = sh - SH_W'(1);
      bias = (PROD_W'(1) <<< half_pos) - PROD_W'(prod[PROD_W-1]);
      biased = prod + bias;
      shifted_full = biased >>> sh;
      shifted = shifted_full[SHIFTED_W-1:0];
      priority if (shifted > SAT_HI) begin
         basis = BASIS_MAX;
      end else if (shifted < SAT_LO) begin
         basis = BASIS_MIN;
      end else begin
         basis = shifted[BASIS_W-1:0];
      end
   end

endmodule

// ===== rtl/core/triangle_v_basis_eval_core.sv =====
`timescale 1ns / 1ps
// Triangle V-system basis evaluator, top level: input, linear, product and result registers.
// rsp_valid rises once a beat has passed the input, linear, product and result registers.
// Throughput: one beat per cycle; busy is never raised, since every stage advances each cycle.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous reset clears the valid pipeline only; payload registers are not reset.
// Depends on tvbe_pkg, tvbe_classify, tvbe_term and tvbe_round.
module triangle_v_basis_eval_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tvbe_pkg::COORD_W-1:0]        req_coord_u,
   input  logic [tvbe_pkg::COORD_W-1:0]        req_coord_v,
   input  logic [tvbe_pkg::COORD_W-1:0]        req_coord_w,
   input  logic [tvbe_pkg::SHIFT_W-1:0]        req_scale_shift,
   output logic                                rsp_valid,
   output logic signed [tvbe_pkg::BASIS_W-1:0] rsp_basis_0,
   output logic signed [tvbe_pkg::BASIS_W-1:0] rsp_basis_1,
   output logic signed [tvbe_pkg::BASIS_W-1:0] rsp_basis_2,
   output logic signed [tvbe_pkg::BASIS_W-1:0] rsp_basis_3,
   output logic signed [tvbe_pkg::BASIS_W-1:0] rsp_basis_4,
   output logic signed [tvbe_pkg::BASIS_W-1:0] rsp_basis_5,
   output logic signed [tvbe_pkg::BASIS_W-1:0] rsp_basis_6,
   output logic signed [tvbe_pkg::BASIS_W-1:0] rsp_basis_7,
   output logic signed [tvbe_pkg::BASIS_W-1:0] rsp_basis_8,
   output tvbe_pkg::region_type                rsp_region_code
);
   import tvbe_pkg::*;

   logic                        accept;
   logic                        in_valid_ff;
   logic                        lin_valid_ff;
   logic                        prod_valid_ff;
   logic                        out_valid_ff;
   logic [COORD_W-1:0]          coord_u_ff;
   logic [COORD_W-1:0]          coord_v_ff;
   logic [COORD_W-1:0]          coord_w_ff;
   logic [SHIFT_W-1:0]          shift_ff;
   logic [SHIFT_W-1:0]          shift2_ff;
   logic [SHIFT_W-1:0]          shift3_ff;
   region_type                  region;
   region_type                  region2_ff;
   region_type                  region3_ff;
   region_type                  region_out_ff;
   logic signed [PROD_W-1:0]    prod [NUM_BASIS];
   logic signed [BASIS_W-1:0]   basis_rnd [NUM_BASIS];
   logic signed [BASIS_W-1:0]   basis_ff [NUM_BASIS];

   assign busy = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         lin_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
         lin_valid_ff <= in_valid_ff;
         prod_valid_ff <= lin_valid_ff;
         out_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         coord_u_ff <= req_coord_u;
         coord_v_ff <= req_coord_v;
         coord_w_ff <= req_coord_w;
         shift_ff <= req_scale_shift;
      end
      shift2_ff <= shift_ff;
      shift3_ff <= shift2_ff;
      region2_ff <= region;
      region3_ff <= region2_ff;
      region_out_ff <= region3_ff;
      for (int i = 0; i < NUM_BASIS; i++) begin
         basis_ff[i] <= basis_rnd[i];
      end
   end

   tvbe_classify u_classify (
      .coord_u (coord_u_ff),
      .coord_v (coord_v_ff),
      .coord_w (coord_w_ff),
      .region  (region)
   );

   for (genvar j = 0; j < NUM_BASIS; j++) begin : g_slot
      tvbe_term u_term (
         .clock   (clock),
         .term    (REGION_TAB[region][j]),
         .coord_u (coord_u_ff),
         .coord_v (coord_v_ff),
         .coord_w (coord_w_ff),
         .prod_ff (prod[j])
      );

      tvbe_round u_round (
         .prod        (prod[j]),
         .scale_shift (shift3_ff),
         .basis       (basis_rnd[j])
      );
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_basis_0 = basis_ff[0];
   assign rsp_basis_1 = basis_ff[1];
   assign rsp_basis_2 = basis_ff[2];
   assign rsp_basis_3 = basis_ff[3];
   assign rsp_basis_4 = basis_ff[4];
   assign rsp_basis_5 = basis_ff[5];
   assign rsp_basis_6 = basis_ff[6];
   assign rsp_basis_7 = basis_ff[7];
   assign rsp_basis_8 = basis_ff[8];
   assign rsp_region_code = region_out_ff;

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##4 rsp_valid)
      else $error("Accepted beat did not produce a result four cycles later.");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("Result strobe without an accepted beat four cycles earlier.");

   a_corner_u_zeros: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_region_code == REG_CORNER_U |->
         rsp_basis_4 == 0 && rsp_basis_5 == 0 && rsp_basis_7 == 0 && rsp_basis_8 == 0)
      else $error("Corner subtriangle of u produced a nonzero unused basis value.");
`endif

endmodule
